// ===== rtl/apsc_pkg.sv =====
package apsc_pkg;

   // Parser position within the path.
   typedef enum logic [2:0] {
      PH_FIRST     = 3'd0,
      PH_AFTER_DOT = 3'd1,
      PH_IDENT     = 3'd2,
      PH_OPEN      = 3'd3,
      PH_STAR      = 3'd4,
      PH_DIGITS    = 3'd5,
      PH_CLOSED    = 3'd6,
      PH_DISCARD   = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ACCEPT  = 2'd1,
      ST_ERROR   = 2'd2,
      ST_DISCARD = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ERR_NONE        = 4'd0,
      ERR_EMPTY       = 4'd1,
      ERR_EXPECT_ID   = 4'd2,
      ERR_UNTERM      = 4'd3,
      ERR_STAR_CLOSE  = 4'd4,
      ERR_TOO_LARGE   = 4'd5,
      ERR_BAD_INDEX   = 4'd6,
      ERR_EXPECT_DOT  = 4'd7,
      ERR_TRAIL_DOT   = 4'd8
   } error_type;

   typedef enum logic [1:0] {
      SEL_FIRST = 2'd0,
      SEL_INDEX = 2'd1,
      SEL_ALL   = 2'd2
   } selector_type;

   localparam logic [7:0] CH_LBRACKET   = 8'h5B;
   localparam logic [7:0] CH_RBRACKET   = 8'h5D;
   localparam logic [7:0] CH_STAR       = 8'h2A;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   localparam int RSP_DATA_W = 56;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

// ===== rtl/attribute_path_syntax_checker.sv =====
// Attribute path syntax checker. Bytes of a dotted path such as name[3].item[*].x enter
// on the req_ stream, one byte per beat, and a beat with the kind bit set in req_tuser
// closes the path. Every request beat produces exactly one response beat in order: it
// marks identifier bytes, reports each completed step with its number, selector kind and
// one-based decimal index, reports acceptance on the closing beat, and flags one of eight
// syntax errors on the beat that shows it. After an error the remaining bytes are flagged
// as discarded until the closing beat, which returns the checker to its initial state.
// The block sustains one beat per clock while rsp_tready does not hold it back: a request
// beat is first captured in an input register, then the parse state and the response
// register are updated from it. The per-beat cost is set by the index update, one
// INDEX_BITS-wide multiply by ten (shift and add) with an overflow compare.
module attribute_path_syntax_checker
   import apsc_pkg::*;
#(
   parameter int INDEX_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] byte_in
   input  logic                  req_tuser,   // [0] kind (1 = end of path)
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] status, [5:2] error_code, [6] name_byte, [7] step_end,
   // [9:8] selector_kind, [41:10] selector_index, [49:42] step_number, [55:50] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ACC_W = INDEX_BITS + 4;

   // Input register stage.
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_kind_ff;
   logic [7:0] s1_byte_ff;

   // Response register stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // Parse state.
   phase_type             phase_ff, phase_in;
   logic [INDEX_BITS-1:0] acc_ff, acc_in;
   logic [7:0]            steps_ff, steps_in;

   logic s2_free, commit, take;

   // The response register can take a new beat when it is empty or being drained.
   assign s2_free    = !rsp_valid_ff || rsp_tready;
   assign commit     = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;
   assign take       = req_tvalid && req_tready;

   // Byte classification for the beat in the input register.
   logic       is_end, id_start, id_char, digit;
   logic [3:0] digit_val;
   logic [ACC_W-1:0] acc_next_wide;
   logic       overflow;

   assign is_end    = s1_kind_ff;
   assign id_start  = is_alpha(s1_byte_ff) || (s1_byte_ff == CH_UNDERSCORE);
   assign digit     = is_digit(s1_byte_ff);
   assign id_char   = id_start || digit;
   assign digit_val = s1_byte_ff[3:0];

   // acc * 10 + digit, computed wide so that any excess over INDEX_BITS shows in the top bits.
   assign acc_next_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                          + {{(ACC_W-4){1'b0}}, digit_val};
   assign overflow      = |acc_next_wide[ACC_W-1:INDEX_BITS];

   // Output decode: what this beat reports.
   status_type   status;
   error_type    err;
   logic         name_byte, step_close;
   selector_type sel_kind;

   always_comb begin
      status     = ST_OK;
      err        = ERR_NONE;
      name_byte  = 1'b0;
      step_close = 1'b0;
      sel_kind   = SEL_FIRST;
      case (phase_ff)
         PH_FIRST, PH_AFTER_DOT: begin
            if (is_end) begin
               err = (phase_ff == PH_FIRST) ? ERR_EMPTY : ERR_TRAIL_DOT;
            end else if (id_start) begin
               name_byte = 1'b1;
            end else begin
               err = ERR_EXPECT_ID;
            end
         end
         PH_IDENT: begin
            if (is_end) begin
               step_close = 1'b1;
               status     = ST_ACCEPT;
            end else if (id_char) begin
               name_byte = 1'b1;
            end else if (s1_byte_ff == CH_DOT) begin
               step_close = 1'b1;
            end else if (s1_byte_ff != CH_LBRACKET) begin
               err = ERR_EXPECT_DOT;
            end
         end
         PH_OPEN: begin
            if (is_end) begin
               err = ERR_UNTERM;
            end else if (s1_byte_ff != CH_STAR && !digit) begin
               err = ERR_BAD_INDEX;
            end
         end
         PH_STAR: begin
            if (!is_end && s1_byte_ff == CH_RBRACKET) begin
               step_close = 1'b1;
               sel_kind   = SEL_ALL;
            end else begin
               err = ERR_STAR_CLOSE;
            end
         end
         PH_DIGITS: begin
            if (is_end) begin
               err = ERR_BAD_INDEX;
            end else if (digit) begin
               if (overflow) err = ERR_TOO_LARGE;
            end else if (s1_byte_ff == CH_RBRACKET && acc_ff != '0) begin
               step_close = 1'b1;
               sel_kind   = SEL_INDEX;
            end else begin
               err = ERR_BAD_INDEX;
            end
         end
         PH_CLOSED: begin
            if (is_end) begin
               status = ST_ACCEPT;
            end else if (s1_byte_ff != CH_DOT) begin
               err = ERR_EXPECT_DOT;
            end
         end
         default: begin
            status = ST_DISCARD;
         end
      endcase
      // An error beat reports only the error, even where a step would have closed.
      if (err != ERR_NONE) begin
         status     = ST_ERROR;
         name_byte  = 1'b0;
         step_close = 1'b0;
         sel_kind   = SEL_FIRST;
      end
   end

   // Next-state logic for the parse phase, index accumulator and step counter.
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      steps_in = steps_ff;
      case (phase_ff)
         PH_FIRST, PH_AFTER_DOT: begin
            phase_in = PH_IDENT;
         end
         PH_IDENT: begin
            if (s1_byte_ff == CH_LBRACKET) begin
               phase_in = PH_OPEN;
            end else if (s1_byte_ff == CH_DOT) begin
               phase_in = PH_AFTER_DOT;
            end
         end
         PH_OPEN: begin
            if (digit) begin
               acc_in   = {{(INDEX_BITS-4){1'b0}}, digit_val};
               phase_in = PH_DIGITS;
            end else begin
               phase_in = PH_STAR;
            end
         end
         PH_STAR: begin
            phase_in = PH_CLOSED;
         end
         PH_DIGITS: begin
            if (digit) begin
               acc_in = acc_next_wide[INDEX_BITS-1:0];
            end else begin
               acc_in   = '0;
               phase_in = PH_CLOSED;
            end
         end
         PH_CLOSED: begin
            phase_in = PH_AFTER_DOT;
         end
         default: begin
            phase_in = PH_DISCARD;
         end
      endcase
      if (step_close && steps_ff != 8'hFF) begin
         steps_in = steps_ff + 8'd1;
      end
      if (err != ERR_NONE) begin
         phase_in = PH_DISCARD;
         acc_in   = acc_ff;
      end
      // The closing beat always restarts the checker.
      if (is_end) begin
         phase_in = PH_FIRST;
         acc_in   = '0;
         steps_in = '0;
      end
   end

   // Response assembly. The index is widened first so any INDEX_BITS yields 32 bits.
   logic [INDEX_BITS+31:0] acc_ext;
   logic [31:0]            sel_index;
   logic [7:0]             step_num;

   assign acc_ext   = {32'd0, acc_ff};
   assign sel_index = (sel_kind == SEL_INDEX) ? acc_ext[31:0] : 32'd0;
   assign step_num  = step_close ? steps_ff : 8'd0;

   assign s1_valid_in  = take ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_FIRST;
         acc_ff       <= '0;
         steps_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            steps_ff <= steps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_kind_ff <= req_tuser;
         s1_byte_ff <= req_tdata;
      end
      if (commit) begin
         rsp_data_ff <= {6'd0, step_num, sel_index, sel_kind, step_close, name_byte,
                         err, status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An error beat never also reports an identifier byte or a completed step.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ST_ERROR |-> rsp_tdata[7:6] == 2'b00)
      else $error("error beat carries name or step flags");

   // A closing beat always returns the parser to its initial state.
   assert property (@(posedge clock) disable iff (reset)
      commit && is_end |=> phase_ff == PH_FIRST && steps_ff == 8'd0 && acc_ff == '0)
      else $error("parser not restarted after end of path");

   // The index field is only populated for a numbered selector.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9:8] != SEL_INDEX |-> rsp_tdata[41:10] == 32'd0)
      else $error("index reported without numbered selector");

   // A numbered step is only closed with a nonzero index.
   assert property (@(posedge clock) disable iff (reset)
      commit && step_close && sel_kind == SEL_INDEX |-> acc_ff != '0)
      else $error("numbered step closed with zero index");

endmodule
